// File: sv/pfk_pkg.sv
// Shared constants, types and the radix-16 divide-by-five digit step for the pit-fill kernel.
// No dependencies.
package pfk_pkg;

	// Configuration port geometry
	localparam int ADDR_W = 4;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_EQ_TOL   = 2'd0;
	localparam logic [1:0] REG_MIN_RAISE = 2'd1;
	localparam logic [1:0] REG_FALLBACK = 2'd2;

	// Register reset values
	localparam logic [15:0] EQ_TOL_RST    = 16'd1;
	localparam logic [15:0] MIN_RAISE_RST = 16'd1;
	localparam logic [19:0] FALLBACK_RST  = 20'd512;

	// Long division by five works on 4-bit digits, this many per pipeline stage
	localparam int DIGIT_W = 4;
	localparam int DIGITS_PER_STAGE = 4;

	// Which rule supplies the raise for a pit
	typedef enum logic {
		MODE_HALF      = 1'b0,
		MODE_TWENTIETH = 1'b1
	} delta_mode_t;

	typedef struct packed {
		logic [3:0] quo;
		logic [2:0] rem;
	} digit_t;

	// One long-division step: t = {remainder, digit}, t <= 79, quotient digit and new remainder
	function automatic digit_t div5_digit(input logic [6:0] t);
		logic [14:0] prod;
		digit_t      d;
		prod  = 15'(t) * 15'd205;
		d.quo = prod[13:10];
		d.rem = 3'(t - 7'(d.quo) * 7'd5);
		return d;
	endfunction

endpackage

// File: sv/pfk_in_if.sv
// Input channel of the pit-fill kernel: valid/ready request with one 3x3 window.
// No dependencies.
interface pfk_in_if #(parameter int HEIGHT_BITS = 32);
	logic                          valid;
	logic                          ready;
	logic signed [HEIGHT_BITS-1:0] center_height;
	logic signed [HEIGHT_BITS-1:0] height_nw;
	logic signed [HEIGHT_BITS-1:0] height_n;
	logic signed [HEIGHT_BITS-1:0] height_ne;
	logic signed [HEIGHT_BITS-1:0] height_w;
	logic signed [HEIGHT_BITS-1:0] height_e;
	logic signed [HEIGHT_BITS-1:0] height_sw;
	logic signed [HEIGHT_BITS-1:0] height_s;
	logic signed [HEIGHT_BITS-1:0] height_se;
	logic [7:0]                    neighbour_valid;
	logic                          is_outflow;

	modport source(
		output valid, center_height, height_nw, height_n, height_ne, height_w, height_e,
		       height_sw, height_s, height_se, neighbour_valid, is_outflow,
		input  ready
	);
	modport sink(
		input  valid, center_height, height_nw, height_n, height_ne, height_w, height_e,
		       height_sw, height_s, height_se, neighbour_valid, is_outflow,
		output ready
	);
endinterface

// File: sv/pfk_out_if.sv
// Output channel of the pit-fill kernel: valid/ready request with the filled height.
// No dependencies.
interface pfk_out_if #(parameter int HEIGHT_BITS = 32);
	logic                          valid;
	logic                          ready;
	logic signed [HEIGHT_BITS-1:0] new_height;
	logic                          is_pit;

	modport source(output valid, new_height, is_pit, input ready);
	modport sink(input valid, new_height, is_pit, output ready);
endinterface

// File: sv/dem_pit_fill_kernel.sv
// 3x3 pit-fill kernel: finds the two lowest distinct neighbour heights and raises pits.
// It accepts one request per cycle while the output is not stalled.
// The stage count is set by the three-level minimum tree and the digit-serial divide by 20.
// Each stage holds while the next one is full and stalled; the output register frees it.
// arst_n clears all valid bits and loads the register defaults; no clearing pass.
// Depends on pfk_pkg, pfk_in_if, pfk_out_if.
module dem_pit_fill_kernel #(
	parameter int HEIGHT_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	pfk_in_if.sink                     cell_in,
	pfk_out_if.source                  cell_out,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pfk_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int HB   = HEIGHT_BITS;
	localparam int QW   = HB - 3;
	localparam int DW   = pfk_pkg::DIGIT_W;
	localparam int DPS  = pfk_pkg::DIGITS_PER_STAGE;
	localparam int NDIG = (QW + DW - 1) / DW;
	localparam int PW   = NDIG * DW;
	localparam int NDS  = (NDIG + DPS - 1) / DPS;
	localparam int SW   = ((HB > 20) ? HB : 20) + 1;
	localparam logic [HB-1:0] SIGN = {1'b1, {(HB-1){1'b0}}};
	localparam logic [HB-1:0] HMAX = '1;

	// Running (lowest, next distinct) pair over a set of neighbours, offset-binary heights
	typedef struct packed {
		logic          has1;
		logic          has2;
		logic [HB-1:0] m1;
		logic [HB-1:0] m2;
	} node_t;

	// Item context carried through the divider stages
	typedef struct packed {
		logic                 pit;
		pfk_pkg::delta_mode_t mode;
		logic                 positive;
		logic [HB-1:0]        m1;
		logic [HB-1:0]        c;
		logic [HB-1:0]        half;
	} ctx_t;

	function automatic node_t leaf(input logic vld, input logic [HB-1:0] h);
		node_t n;
		n.has1 = vld;
		n.has2 = 1'b0;
		n.m1   = h ^ SIGN;
		n.m2   = '0;
		return n;
	endfunction

	function automatic node_t merge(input node_t a, input node_t b);
		node_t         r;
		logic [HB-1:0] lo;
		logic [HB-1:0] best;
		logic          found;
		logic [HB-1:0] cand [4];
		logic          ok   [4];
		if (!a.has1) begin
			r = b;
		end else if (!b.has1) begin
			r = a;
		end else begin
			lo      = (b.m1 < a.m1) ? b.m1 : a.m1;
			cand[0] = a.m1;
			ok[0]   = (a.m1 != lo);
			cand[1] = a.m2;
			ok[1]   = a.has2;
			cand[2] = b.m1;
			ok[2]   = (b.m1 != lo);
			cand[3] = b.m2;
			ok[3]   = b.has2;
			found   = 1'b0;
			best    = '0;
			for (int i = 0; i < 4; i++) begin
				if (ok[i] && (!found || cand[i] < best)) begin
					best  = cand[i];
					found = 1'b1;
				end
			end
			r.has1 = 1'b1;
			r.has2 = found;
			r.m1   = lo;
			r.m2   = best;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- configuration
	logic [15:0] eq_tol_q;
	logic [15:0] min_raise_q;
	logic [19:0] fallback_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[pfk_pkg::ADDR_W-1:2];

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_tol_q    <= pfk_pkg::EQ_TOL_RST;
			min_raise_q <= pfk_pkg::MIN_RAISE_RST;
			fallback_q  <= pfk_pkg::FALLBACK_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				pfk_pkg::REG_EQ_TOL:    eq_tol_q    <= pwdata[15:0];
				pfk_pkg::REG_MIN_RAISE: min_raise_q <= pwdata[15:0];
				pfk_pkg::REG_FALLBACK:  fallback_q  <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (cfg_idx)
			pfk_pkg::REG_EQ_TOL:    prdata = 32'(eq_tol_q);
			pfk_pkg::REG_MIN_RAISE: prdata = 32'(min_raise_q);
			pfk_pkg::REG_FALLBACK:  prdata = 32'(fallback_q);
			default:                prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- stall chain
	logic           v_s1, v_s2, v_s3, v_s4, vout_q;
	logic           en_s1, en_s2, en_s3, en_s4, en_o;
	logic [NDS-1:0] v_sd;
	logic [NDS-1:0] en_sd;

	// A stage loads when empty or when its successor loads
	assign en_o          = !vout_q || cell_out.ready;
	assign en_s4         = !v_s4 || en_sd[0];
	assign en_s3         = !v_s3 || en_s4;
	assign en_s2         = !v_s2 || en_s3;
	assign en_s1         = !v_s1 || en_s2;
	assign cell_in.ready = en_s1;

	// ---------------------------------------------------------------- stage 1: pairs
	logic [HB-1:0] hv [8];
	node_t         n1_d [4];
	node_t         node_s1 [4];
	logic [HB-1:0] c_s1;
	logic          outflow_s1;

	assign hv[0] = cell_in.height_nw;
	assign hv[1] = cell_in.height_n;
	assign hv[2] = cell_in.height_ne;
	assign hv[3] = cell_in.height_w;
	assign hv[4] = cell_in.height_e;
	assign hv[5] = cell_in.height_sw;
	assign hv[6] = cell_in.height_s;
	assign hv[7] = cell_in.height_se;

	// Merge neighbours two by two
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			n1_d[k] = merge(leaf(cell_in.neighbour_valid[2*k], hv[2*k]),
			                leaf(cell_in.neighbour_valid[2*k+1], hv[2*k+1]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= cell_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && cell_in.valid) begin
			node_s1    <= n1_d;
			c_s1       <= cell_in.center_height ^ SIGN;
			outflow_s1 <= cell_in.is_outflow;
		end
	end

	// ---------------------------------------------------------------- stage 2: quads
	node_t         node_s2 [2];
	logic [HB-1:0] c_s2;
	logic          outflow_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			node_s2[0] <= merge(node_s1[0], node_s1[1]);
			node_s2[1] <= merge(node_s1[2], node_s1[3]);
			c_s2       <= c_s1;
			outflow_s2 <= outflow_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3: all eight
	node_t         n3_d;
	logic          has1_s3;
	logic [HB-1:0] m1_s3;
	logic [HB-1:0] m2_s3;
	logic [HB-1:0] c_s3;
	logic          outflow_s3;

	assign n3_d = merge(node_s2[0], node_s2[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	// Take the lowest height as second when no other distinct height exists
	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			has1_s3    <= n3_d.has1;
			m1_s3      <= n3_d.m1;
			m2_s3      <= n3_d.has2 ? n3_d.m2 : n3_d.m1;
			c_s3       <= c_s2;
			outflow_s3 <= outflow_s2;
		end
	end

	// ---------------------------------------------------------------- stage 4: pit test, rule
	logic [HB-1:0] d21;
	logic [HB:0]   dc;
	ctx_t          ctx_d4;
	ctx_t          ctx_s4;
	logic [PW-1:0] word_s4;

	assign d21 = m2_s3 - m1_s3;
	assign dc  = {1'b0, m1_s3} - {1'b0, c_s3};

	// Pick the raise rule; for a pit, dc is the distance from the cell to the lowest neighbour
	always_comb begin
		ctx_d4.pit = has1_s3 && !outflow_s3 && !dc[HB];
		ctx_d4.m1  = m1_s3;
		ctx_d4.c   = c_s3;
		if (d21 > HB'(eq_tol_q)) begin
			ctx_d4.mode = pfk_pkg::MODE_HALF;
			ctx_d4.half = d21 >> 1;
		end else if (dc[HB-1:0] <= HB'(eq_tol_q)) begin
			ctx_d4.mode = pfk_pkg::MODE_TWENTIETH;
			ctx_d4.half = '0;
		end else begin
			ctx_d4.mode = pfk_pkg::MODE_HALF;
			ctx_d4.half = dc[HB-1:0] >> 1;
		end
		ctx_d4.positive = (ctx_d4.mode == pfk_pkg::MODE_HALF) || (c_s3 > SIGN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	// Dividend is the positive height over four; the divider then divides by five
	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			ctx_s4  <= ctx_d4;
			word_s4 <= PW'(c_s3[HB-2:2]);
		end
	end

	// ---------------------------------------------------------------- divide by five, digit serial
	ctx_t          ctx_sd  [NDS];
	logic [PW-1:0] word_sd [NDS];
	logic [2:0]    rem_sd  [NDS];

	for (genvar j = 0; j < NDS; j++) begin : g_div
		ctx_t          ctx_in;
		logic [PW-1:0] w_in;
		logic [PW-1:0] w_nx;
		logic [2:0]    r_in;
		logic [2:0]    r_nx;
		logic          v_in;

		if (j == 0) begin : g_first
			assign ctx_in = ctx_s4;
			assign w_in   = word_s4;
			assign r_in   = '0;
			assign v_in   = v_s4;
		end else begin : g_next
			assign ctx_in = ctx_sd[j-1];
			assign w_in   = word_sd[j-1];
			assign r_in   = rem_sd[j-1];
			assign v_in   = v_sd[j-1];
		end

		if (j == NDS - 1) begin : g_last
			assign en_sd[j] = !v_sd[j] || en_o;
		end else begin : g_mid
			assign en_sd[j] = !v_sd[j] || en_sd[j+1];
		end

		// Replace the next digits, top first, by quotient digits
		always_comb begin
			pfk_pkg::digit_t dg;
			int              k;
			w_nx = w_in;
			r_nx = r_in;
			for (int i = 0; i < DPS; i++) begin
				k = NDIG - 1 - j * DPS - i;
				if (k >= 0) begin
					dg                = pfk_pkg::div5_digit({r_nx, w_nx[k*DW +: DW]});
					w_nx[k*DW +: DW]  = dg.quo;
					r_nx              = dg.rem;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[j] <= 1'b0;
			end else if (en_sd[j]) begin
				v_sd[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_sd[j] && v_in) begin
				ctx_sd[j]  <= ctx_in;
				word_sd[j] <= w_nx;
				rem_sd[j]  <= r_nx;
			end
		end
	end

	// ---------------------------------------------------------------- final: raise and saturate
	ctx_t          ctx_f;
	logic [HB-1:0] delta;
	logic          use_delta;
	logic [SW-1:0] add_f;
	logic [SW-1:0] sum_f;
	logic [HB-1:0] res_d;
	logic [HB-1:0] res_q;
	logic          pit_q;

	assign ctx_f = ctx_sd[NDS-1];

	always_comb begin
		delta     = (ctx_f.mode == pfk_pkg::MODE_HALF) ? ctx_f.half : HB'(word_sd[NDS-1]);
		use_delta = ctx_f.positive && (delta > HB'(min_raise_q));
		add_f     = use_delta ? SW'(delta) : SW'(fallback_q);
		sum_f     = SW'(ctx_f.m1) + add_f;
		if (!ctx_f.pit) begin
			res_d = ctx_f.c;
		end else if (sum_f > SW'(HMAX)) begin
			res_d = HMAX;
		end else begin
			res_d = sum_f[HB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout_q <= 1'b0;
		end else if (en_o) begin
			vout_q <= v_sd[NDS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && v_sd[NDS-1]) begin
			res_q <= res_d;
			pit_q <= ctx_f.pit;
		end
	end

	// Drive the result, back from offset binary
	assign cell_out.valid      = vout_q;
	assign cell_out.new_height = res_q ^ SIGN;
	assign cell_out.is_pit     = pit_q;

endmodule
